>>> hw/rtl/ecs_pkg.sv
`timescale 1ns / 1ps
// ecs_pkg: types, signal codes and decode tables of the elevator call scheduler
// no dependencies

package ecs_pkg;

    localparam int KEY_W   = 16;
    localparam int RX_W    = 8;
    localparam int SIG_W   = 8;
    localparam int FLOOR_W = 3;
    localparam int SLOT_N  = 8;
    localparam int SLOT_W  = 3;

    // signal byte codes
    localparam logic [SIG_W-1:0] SIG_SAME_FLOOR = 8'hf8;
    localparam logic [SIG_W-1:0] SIG_IDLE       = 8'hff;
    localparam logic [SIG_W-1:0] SIG_REQ_BASE   = 8'hf0;

    // received byte codes
    localparam logic [RX_W-1:0] RX_RELEASE = 8'h08;
    localparam logic [3:0] CODE_CLR_OPEN   = 4'h4;
    localparam logic [3:0] CODE_CLR_CLOSE  = 4'h5;
    localparam logic [3:0] CODE_CLR_DANGER = 4'h6;

    // lamp bits
    localparam int LAMP_OPEN   = 13;
    localparam int LAMP_CLOSE  = 14;
    localparam int LAMP_DANGER = 15;

    localparam logic [FLOOR_W-1:0] FLOOR_RESET = 3'd1;
    localparam logic [FLOOR_W-1:0] FLOOR_TOP   = 3'd5;

    typedef struct packed {
        logic [KEY_W-1:0] key_mask;
        logic [RX_W-1:0]  received_byte;
    } t_item;

    typedef struct packed {
        logic [SIG_W-1:0]   sig;
        logic [KEY_W-1:0]   lamps;
        logic [FLOOR_W-1:0] floor;
        logic               down;
        logic [SLOT_N-1:0]  pending;
    } t_state;

    typedef struct packed {
        logic               hit;
        logic [FLOOR_W-1:0] floor;
        logic               down;
        logic [2:0]         hall;
        logic [SLOT_W-1:0]  slot;
    } t_arrival;

    // keys 0..12 that serve a given floor
    function automatic logic [KEY_W-1:0] floor_keys(input logic [FLOOR_W-1:0] f);
        logic [KEY_W-1:0] m;
        m = '0;
        unique case (f)
            3'd1:    m = 16'h0101;
            3'd2:    m = 16'h0222;
            3'd3:    m = 16'h0444;
            3'd4:    m = 16'h0888;
            3'd5:    m = 16'h1010;
            default: m = '0;
        endcase
        return m;
    endfunction

    // arrival decode of the upper nibble of the received byte
    function automatic t_arrival arrival_decode(input logic [3:0] code);
        t_arrival a;
        a = '0;
        unique case (code)
            4'h0:    a = '{hit: 1'b1, floor: 3'd1, down: 1'b0, hall: 3'd0, slot: 3'd0};
            4'h1:    a = '{hit: 1'b1, floor: 3'd2, down: 1'b0, hall: 3'd1, slot: 3'd1};
            4'h2:    a = '{hit: 1'b1, floor: 3'd3, down: 1'b0, hall: 3'd2, slot: 3'd2};
            4'h3:    a = '{hit: 1'b1, floor: 3'd4, down: 1'b0, hall: 3'd3, slot: 3'd3};
            4'h9:    a = '{hit: 1'b1, floor: 3'd2, down: 1'b1, hall: 3'd5, slot: 3'd7};
            4'ha:    a = '{hit: 1'b1, floor: 3'd3, down: 1'b1, hall: 3'd6, slot: 3'd6};
            4'hb:    a = '{hit: 1'b1, floor: 3'd4, down: 1'b1, hall: 3'd7, slot: 3'd5};
            4'hc:    a = '{hit: 1'b1, floor: 3'd5, down: 1'b1, hall: 3'd4, slot: 3'd4};
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

>>> hw/rtl/ecs_req_if.sv
`timescale 1ns / 1ps
// ecs_req_if: input item channel of the elevator call scheduler
// depends on ecs_pkg

interface ecs_req_if;
    logic                      valid;
    logic                      ready;
    logic [ecs_pkg::KEY_W-1:0] key_mask;
    logic [ecs_pkg::RX_W-1:0]  received_byte;

    modport source (output valid, output key_mask, output received_byte, input ready);
    modport sink   (input valid, input key_mask, input received_byte, output ready);
endinterface

>>> hw/rtl/ecs_rsp_if.sv
`timescale 1ns / 1ps
// ecs_rsp_if: result item channel of the elevator call scheduler
// depends on ecs_pkg

interface ecs_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [ecs_pkg::SIG_W-1:0]   signal_byte;
    logic [ecs_pkg::KEY_W-1:0]   lamp_mask;
    logic [ecs_pkg::FLOOR_W-1:0] current_floor;
    logic                        moving_down;
    logic [ecs_pkg::SLOT_N-1:0]  pending_mask;

    modport source (output valid, output signal_byte, output lamp_mask,
                    output current_floor, output moving_down, output pending_mask,
                    input ready);
    modport sink   (input valid, input signal_byte, input lamp_mask,
                    input current_floor, input moving_down, input pending_mask,
                    output ready);
endinterface

>>> hw/rtl/ecs_pass.sv
`timescale 1ns / 1ps
// ecs_pass: one controller pass, keys, slot activation, rotating scan, rx decode
// depends on ecs_pkg

module ecs_pass (
    input  ecs_pkg::t_state i_state,
    input  ecs_pkg::t_item  i_item,
    output ecs_pkg::t_state o_state
);

    logic [ecs_pkg::KEY_W-1:0]   fk;
    logic                        same_hit;
    logic [ecs_pkg::KEY_W-1:0]   lamps1;
    logic [ecs_pkg::SIG_W-1:0]   sig1;
    logic [ecs_pkg::SLOT_N-1:0]  p;
    logic                        dn;
    logic [ecs_pkg::SLOT_W-1:0]  start;
    logic [2*ecs_pkg::SLOT_N-1:0] dbl;
    logic [ecs_pkg::SLOT_N-1:0]  rot;
    logic                        found;
    logic [ecs_pkg::SLOT_W-1:0]  idx;
    logic [ecs_pkg::SLOT_W-1:0]  slot;
    logic [ecs_pkg::SIG_W-1:0]   sig2;
    logic [3:0]                  code;
    ecs_pkg::t_arrival           arr;
    logic [3:0]                  car_bit;

    always_comb begin
        // keys: same-floor keys ask for the doors, the rest light lamps
        fk       = ecs_pkg::floor_keys(i_state.floor);
        same_hit = |(i_item.key_mask & fk);
        lamps1   = i_state.lamps | (i_item.key_mask & ~fk);
        sig1     = same_hit ? ecs_pkg::SIG_SAME_FLOOR : i_state.sig;

        // slot activation
        dn   = i_state.down;
        p    = i_state.pending;
        p[0] = p[0] | lamps1[8]  | lamps1[0];
        p[1] = p[1] | (lamps1[9]  & ~dn) | lamps1[1];
        p[2] = p[2] | (lamps1[10] & ~dn) | lamps1[2];
        p[3] = p[3] | (lamps1[11] & ~dn) | lamps1[3];
        p[4] = p[4] | lamps1[12] | lamps1[4];
        p[5] = p[5] | (lamps1[11] & dn) | lamps1[7];
        p[6] = p[6] | (lamps1[10] & dn) | lamps1[6];
        p[7] = p[7] | (lamps1[9]  & dn) | lamps1[5];

        // rotating scan start
        if (!dn || i_state.floor == ecs_pkg::FLOOR_TOP) begin
            start = i_state.floor - 3'd1;
        end else begin
            start = 3'd1 - i_state.floor;
        end
        dbl   = {p, p} >> start;
        rot   = dbl[ecs_pkg::SLOT_N-1:0];
        found = |rot;
        idx   = '0;
        for (int i = ecs_pkg::SLOT_N - 1; i >= 0; i--) begin
            if (rot[i]) begin
                idx = ecs_pkg::SLOT_W'(i);
            end
        end
        slot = start + idx;
        sig2 = found ? (ecs_pkg::SIG_REQ_BASE | {5'd0, slot}) : sig1;

        // received byte decode
        code    = i_item.received_byte[7:4];
        arr     = ecs_pkg::arrival_decode(code);
        car_bit = 4'd7 + {1'b0, arr.floor};

        o_state         = i_state;
        o_state.sig     = (i_item.received_byte == ecs_pkg::RX_RELEASE) ? ecs_pkg::SIG_IDLE
                                                                         : sig2;
        o_state.lamps   = lamps1;
        o_state.pending = p;
        if (arr.hit) begin
            o_state.floor            = arr.floor;
            o_state.down             = arr.down;
            o_state.lamps[arr.hall]  = 1'b0;
            o_state.lamps[car_bit]   = 1'b0;
            o_state.pending[arr.slot] = 1'b0;
        end else if (code == ecs_pkg::CODE_CLR_OPEN) begin
            o_state.lamps[ecs_pkg::LAMP_OPEN] = 1'b0;
        end else if (code == ecs_pkg::CODE_CLR_CLOSE) begin
            o_state.lamps[ecs_pkg::LAMP_CLOSE] = 1'b0;
        end else if (code == ecs_pkg::CODE_CLR_DANGER) begin
            o_state.lamps[ecs_pkg::LAMP_DANGER] = 1'b0;
        end
    end

endmodule

>>> hw/rtl/elevator_call_scheduler_unit.sv
`timescale 1ns / 1ps
// elevator_call_scheduler_unit: top level of the five-floor elevator call scheduler
// depends on ecs_pkg, ecs_req_if, ecs_rsp_if and ecs_pass

// Each input item is one pass of the car controller loop: a mask of pressed keys and
// the byte received from the master controller. The unit keeps the 16 request lamps,
// 8 pending stop slots, current floor, travel direction and outgoing signal byte, and
// returns one result item per input item holding all of them as they stand after the
// pass. Throughput is one item per clock while the output side takes results; a stalled
// result holds the flow. The input register takes a new item while the previous result
// still waits on the output side. The item lands in the input register at its accept
// edge, and the pass then loads the state/result register. The state registers double as
// the result register, so the pass for the next item fires only in a cycle where the
// current result is taken or none is waiting; the combinational pass in ecs_pass is
// what sets the rate. The input side is not ready while reset is held.

module elevator_call_scheduler_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ecs_req_if.sink   i_req,
    ecs_rsp_if.source o_rsp
);

    // input register
    logic            r_in_valid;
    ecs_pkg::t_item  r_item;
    // state, which is also the result register
    logic            r_out_valid;
    ecs_pkg::t_state r_state;
    ecs_pkg::t_state n_state;

    logic advance;
    logic in_fire;

    // the pass runs when an item waits and the result slot is free or being drained
    assign advance     = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = i_rst_n && (!r_in_valid || advance);
    assign in_fire     = i_req.valid && i_req.ready;

    ecs_pass u_pass (
        .i_state (r_state),
        .i_item  (r_item),
        .o_state (n_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_state.sig     <= ecs_pkg::SIG_IDLE;
            r_state.lamps   <= '0;
            r_state.floor   <= ecs_pkg::FLOOR_RESET;
            r_state.down    <= 1'b0;
            r_state.pending <= '0;
        end else begin
            if (in_fire) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload register needs no reset
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_item.key_mask      <= i_req.key_mask;
            r_item.received_byte <= i_req.received_byte;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.signal_byte   = r_state.sig;
    assign o_rsp.lamp_mask     = r_state.lamps;
    assign o_rsp.current_floor = r_state.floor;
    assign o_rsp.moving_down   = r_state.down;
    assign o_rsp.pending_mask  = r_state.pending;

    // floor stays within the building
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.floor >= 3'd1 && r_state.floor <= ecs_pkg::FLOOR_TOP)
        else $error("floor out of range");

    // every signal code lives in the upper 0xf page
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.sig[7:4] == 4'hf)
        else $error("signal byte outside code page");

    // state only moves on a pass
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_state))
        else $error("state changed without a pass");

    // a release byte always leaves the signal idle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_item.received_byte == ecs_pkg::RX_RELEASE
        |=> r_state.sig == ecs_pkg::SIG_IDLE)
        else $error("release byte did not idle the signal");

endmodule
